// ===== design/cpvg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpvg_pkg: shared types and constants
// Holds register indexes, CORDIC constants and the arctangent table.
// ----------------------------------------------------------------------------
package cpvg_pkg;

    localparam int FRAC_BITS    = 4;
    localparam int COORD_W      = 13 + FRAC_BITS;  // Q13.FRAC_BITS coordinates
    localparam int PHASE_BITS   = 24;
    localparam int CORDIC_STEPS = 20;
    localparam int UNIT_SHIFT   = 30;
    localparam int CW           = 34;  // CORDIC datapath width, Q2.30 plus guard
    localparam int ZW           = 25;  // angle residue width, signed
    localparam logic signed [CW-1:0] CORDIC_START = 34'sd652032874;
    localparam int CFG_IDX_W    = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SIDE_COUNT    = 2'd0,
        REG_CIRCLE_RADIUS = 2'd1,
        REG_OUTLINE_WIDTH = 2'd2,
        REG_UNUSED        = 2'd3
    } cfg_reg_t;

    function automatic logic signed [ZW-1:0] turn_atan(input int k);
        logic signed [ZW-1:0] v;
        case (k)
            0:       v = 25'sd2097152;
            1:       v = 25'sd1238021;
            2:       v = 25'sd654136;
            3:       v = 25'sd332050;
            4:       v = 25'sd166669;
            5:       v = 25'sd83416;
            6:       v = 25'sd41718;
            7:       v = 25'sd20860;
            8:       v = 25'sd10430;
            9:       v = 25'sd5215;
            10:      v = 25'sd2608;
            11:      v = 25'sd1304;
            12:      v = 25'sd652;
            13:      v = 25'sd326;
            14:      v = 25'sd163;
            15:      v = 25'sd81;
            16:      v = 25'sd41;
            17:      v = 25'sd20;
            18:      v = 25'sd10;
            19:      v = 25'sd5;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== design/cpvg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpvg channel interfaces
// Valid/ready channels for vertex requests, results and register writes.
// ----------------------------------------------------------------------------
interface cpvg_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] vertex_index;
    modport source (output valid, output vertex_index, input ready);
    modport sink   (input valid, input vertex_index, output ready);
endinterface

interface cpvg_out_if;
    logic                          valid;
    logic                          ready;
    logic [cpvg_pkg::COORD_W-1:0]  rim_x;
    logic [cpvg_pkg::COORD_W-1:0]  rim_y;
    logic [cpvg_pkg::COORD_W-1:0]  fill_x;
    logic [cpvg_pkg::COORD_W-1:0]  fill_y;
    logic [8:0]                    fan_second;
    logic [8:0]                    fan_third;
    logic                          bad_request;
    modport source (output valid, output rim_x, output rim_y, output fill_x,
                    output fill_y, output fan_second, output fan_third,
                    output bad_request, input ready);
    modport sink   (input valid, input rim_x, input rim_y, input fill_x,
                    input fill_y, input fan_second, input fan_third,
                    input bad_request, output ready);
endinterface

interface cpvg_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/cpvg_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpvg_divider: pipelined restoring divider
// Computes floor((idx << 24) / sides), one quotient bit per stage.
// ----------------------------------------------------------------------------
module cpvg_divider #(
    parameter int IDX_W  = 8,
    parameter int SIDE_W = 9,
    parameter int QW     = 24,
    parameter int TAG_W  = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              in_valid,
    input  logic [IDX_W-1:0]  idx,
    input  logic [SIDE_W-1:0] sides,
    input  logic [TAG_W-1:0]  in_tag,
    output logic              out_valid,
    output logic [QW-1:0]     quotient,
    output logic [TAG_W-1:0]  out_tag
);
    // idx < sides, so the remainder stays below sides for all fractional bits
    localparam int RW = SIDE_W + 1;

    logic              vld_reg  [QW+1];
    logic [RW-1:0]     rem_reg  [QW+1];
    logic [QW-1:0]     quo_reg  [QW+1];
    logic [SIDE_W-1:0] div_reg  [QW+1];
    logic [TAG_W-1:0]  tag_reg  [QW+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= QW; s++)
                vld_reg[s] <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg[0] <= in_valid;
            for (int s = 1; s <= QW; s++)
                vld_reg[s] <= vld_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rem_reg[0] <= RW'(idx);
            quo_reg[0] <= '0;
            div_reg[0] <= sides;
            tag_reg[0] <= in_tag;
            for (int s = 1; s <= QW; s++)
            begin
                logic [RW-1:0] t;
                t = {rem_reg[s-1][RW-2:0], 1'b0};
                if (t >= RW'(div_reg[s-1]))
                begin
                    rem_reg[s] <= t - RW'(div_reg[s-1]);
                    quo_reg[s] <= {quo_reg[s-1][QW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[s] <= t;
                    quo_reg[s] <= {quo_reg[s-1][QW-2:0], 1'b0};
                end
                div_reg[s] <= div_reg[s-1];
                tag_reg[s] <= tag_reg[s-1];
            end
        end
    end

    assign out_valid = vld_reg[QW];
    assign quotient  = quo_reg[QW];
    assign out_tag   = tag_reg[QW];
endmodule

// ===== design/cpvg_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpvg_cordic: pipelined rotation CORDIC
// One micro-rotation per stage, then quadrant fold into cos and sin.
// ----------------------------------------------------------------------------
module cpvg_cordic #(
    parameter int TAG_W = 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         advance,
    input  logic                         in_valid,
    input  logic [cpvg_pkg::PHASE_BITS-1:0] phase,
    input  logic [TAG_W-1:0]             in_tag,
    output logic                         out_valid,
    output logic signed [cpvg_pkg::CW-1:0] cos_q,
    output logic signed [cpvg_pkg::CW-1:0] sin_q,
    output logic [TAG_W-1:0]             out_tag
);
    import cpvg_pkg::*;

    localparam int N = CORDIC_STEPS;

    logic                vld_reg [N+2];
    logic signed [CW-1:0] x_reg  [N+1];
    logic signed [CW-1:0] y_reg  [N+1];
    logic signed [ZW-1:0] z_reg  [N+1];
    logic [1:0]          q_reg   [N+1];
    logic [TAG_W-1:0]    tag_reg [N+2];
    logic signed [CW-1:0] c_reg;
    logic signed [CW-1:0] s_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= N + 1; s++)
                vld_reg[s] <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg[0] <= in_valid;
            for (int s = 1; s <= N + 1; s++)
                vld_reg[s] <= vld_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x_reg[0]   <= CORDIC_START;
            y_reg[0]   <= '0;
            z_reg[0]   <= ZW'(phase[PHASE_BITS-3:0]);
            q_reg[0]   <= phase[PHASE_BITS-1:PHASE_BITS-2];
            tag_reg[0] <= in_tag;
            for (int k = 0; k < N; k++)
            begin
                if (!z_reg[k][ZW-1])
                begin
                    x_reg[k+1] <= x_reg[k] - (y_reg[k] >>> k);
                    y_reg[k+1] <= y_reg[k] + (x_reg[k] >>> k);
                    z_reg[k+1] <= z_reg[k] - turn_atan(k);
                end
                else
                begin
                    x_reg[k+1] <= x_reg[k] + (y_reg[k] >>> k);
                    y_reg[k+1] <= y_reg[k] - (x_reg[k] >>> k);
                    z_reg[k+1] <= z_reg[k] + turn_atan(k);
                end
                q_reg[k+1]   <= q_reg[k];
                tag_reg[k+1] <= tag_reg[k];
            end
            case (q_reg[N])
                2'd0:
                begin
                    c_reg <= x_reg[N];
                    s_reg <= y_reg[N];
                end
                2'd1:
                begin
                    c_reg <= -y_reg[N];
                    s_reg <= x_reg[N];
                end
                2'd2:
                begin
                    c_reg <= -x_reg[N];
                    s_reg <= -y_reg[N];
                end
                default:
                begin
                    c_reg <= y_reg[N];
                    s_reg <= -x_reg[N];
                end
            endcase
            tag_reg[N+1] <= tag_reg[N];
        end
    end

    assign out_valid = vld_reg[N+1];
    assign cos_q     = c_reg;
    assign sin_q     = s_reg;
    assign out_tag   = tag_reg[N+1];
endmodule

// ===== design/cpvg_place.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpvg_place: coordinate scaling
// Multiplies radius by the unit vector, rounds, offsets and saturates.
// ----------------------------------------------------------------------------
module cpvg_place #(
    parameter int COORD_W = 17
) (
    input  logic                          clk,
    input  logic                          advance,
    input  logic [15:0]                   radius,
    input  logic [15:0]                   offset,
    input  logic signed [cpvg_pkg::CW-1:0] unit,
    output logic [COORD_W-1:0]            coord
);
    import cpvg_pkg::*;

    localparam int PW = CW + 17;

    // split 16 x 34 into two halves of the unit to keep multipliers narrow
    logic signed [16+17:0]  lo_reg;
    logic signed [16+17:0]  hi_reg;
    logic [15:0]            off1_reg;
    logic signed [PW+1:0]   sum_reg;
    logic [15:0]            off2_reg;
    logic [COORD_W-1:0]     coord_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            lo_reg   <= $signed({1'b0, radius}) * $signed({1'b0, unit[16:0]});
            hi_reg   <= $signed({1'b0, radius}) * $signed(unit[CW-1:17]);
            off1_reg <= offset;
            sum_reg  <= ((PW+2)'(hi_reg) <<< 17) + (PW+2)'(lo_reg)
                        + (PW+2)'(1 << (UNIT_SHIFT - 1));
            off2_reg <= off1_reg;
        end
    end

    // keep the whole sum signed so the shift rounds toward minus infinity
    logic signed [PW+1:0] v;
    always_comb
    begin
        v = (sum_reg >>> UNIT_SHIFT) + $signed((PW+2)'(off2_reg));
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (v < 0)
                coord_reg <= '0;
            else if (v > (PW+2)'((1 << COORD_W) - 1))
                coord_reg <= '1;
            else
                coord_reg <= COORD_W'(v);
        end
    end

    assign coord = coord_reg;
endmodule

// ===== design/circle_polygon_vertex_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_polygon_vertex_generator: regular polygon rim point generator
// Divider, CORDIC and scaling pipelines give rim and fill points per index.
// ----------------------------------------------------------------------------
// Pipeline: 25 divider stages, 22 CORDIC stages and 3 scaling stages lie between
// request accept and result valid; the output register adds none.
// Throughput: one item per cycle; the whole pipeline advances as one unit
// and holds when the output register is full and not taken.
// Reset: rst_n asynchronously clears valid bits and restores side_count 32,
// circle_radius 4096, outline_width 0.
module circle_polygon_vertex_generator #(
    parameter int MAX_SIDES = 256
) (
    input  logic          clk,
    input  logic          rst_n,
    cpvg_in_if.sink       req,
    cpvg_out_if.source    rsp,
    cpvg_cfg_if.sink      cfg
);
    import cpvg_pkg::*;

    // tag: bad flag, index
    localparam int TAG_W   = 1 + 8;

    logic [8:0]  side_count_reg;
    logic [15:0] circle_radius_reg;
    logic [15:0] outline_width_reg;

    // register writes, accepted at any time (software keeps the block idle)
    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_count_reg    <= 9'd32;
            circle_radius_reg <= 16'd4096;
            outline_width_reg <= 16'd0;
        end
        else if (cfg.valid)
        begin
            case (cfg_reg_t'(cfg.index))
                REG_SIDE_COUNT:    side_count_reg    <= cfg.data[8:0];
                REG_CIRCLE_RADIUS: circle_radius_reg <= cfg.data;
                REG_OUTLINE_WIDTH: outline_width_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // advance everything unless the output holds an untaken result
    logic advance;
    assign advance   = !rsp.valid || rsp.ready;
    assign req.ready = advance;

    // reject check at entry; bad items ride the pipeline as bubbles with a flag
    logic bad_in;
    always_comb
    begin
        bad_in = (side_count_reg < 9'd3)
              || (32'(side_count_reg) > MAX_SIDES)
              || ({1'b0, req.vertex_index} >= side_count_reg)
              || (outline_width_reg >= circle_radius_reg);
    end

    logic                   div_valid;
    logic [PHASE_BITS-1:0]  phase;
    logic [TAG_W-1:0]       div_tag;

    cpvg_divider #(
        .IDX_W (8),
        .SIDE_W(9),
        .QW    (PHASE_BITS),
        .TAG_W (TAG_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_valid (req.valid),
        .idx      (bad_in ? 8'd0 : req.vertex_index),
        .sides    (bad_in ? 9'd3 : side_count_reg),
        .in_tag   ({bad_in, req.vertex_index}),
        .out_valid(div_valid),
        .quotient (phase),
        .out_tag  (div_tag)
    );

    logic                 cor_valid;
    logic signed [CW-1:0] cos_q;
    logic signed [CW-1:0] sin_q;
    logic [TAG_W-1:0]     cor_tag;

    cpvg_cordic #(
        .TAG_W(TAG_W)
    ) u_cordic (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_valid (div_valid),
        .phase    (phase),
        .in_tag   (div_tag),
        .out_valid(cor_valid),
        .cos_q    (cos_q),
        .sin_q    (sin_q),
        .out_tag  (cor_tag)
    );

    logic [15:0] inner;
    assign inner = circle_radius_reg - outline_width_reg;

    logic [COORD_W-1:0] rx;
    logic [COORD_W-1:0] ry;
    logic [COORD_W-1:0] fx;
    logic [COORD_W-1:0] fy;

    cpvg_place #(.COORD_W(COORD_W)) u_rx (.clk(clk), .advance(advance),
        .radius(circle_radius_reg), .offset(circle_radius_reg), .unit(cos_q), .coord(rx));
    cpvg_place #(.COORD_W(COORD_W)) u_ry (.clk(clk), .advance(advance),
        .radius(circle_radius_reg), .offset(circle_radius_reg), .unit(sin_q), .coord(ry));
    cpvg_place #(.COORD_W(COORD_W)) u_fx (.clk(clk), .advance(advance),
        .radius(inner), .offset(circle_radius_reg), .unit(cos_q), .coord(fx));
    cpvg_place #(.COORD_W(COORD_W)) u_fy (.clk(clk), .advance(advance),
        .radius(inner), .offset(circle_radius_reg), .unit(sin_q), .coord(fy));

    // match the three scaling stages
    logic             pv_reg  [3];
    logic [TAG_W-1:0] ptag_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < 3; s++)
                pv_reg[s] <= 1'b0;
        end
        else if (advance)
        begin
            pv_reg[0] <= cor_valid;
            pv_reg[1] <= pv_reg[0];
            pv_reg[2] <= pv_reg[1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ptag_reg[0] <= cor_tag;
            ptag_reg[1] <= ptag_reg[0];
            ptag_reg[2] <= ptag_reg[1];
        end
    end

    logic       bad_out;
    logic [7:0] idx_out;
    logic [8:0] fan2;
    assign bad_out = ptag_reg[2][8];
    assign idx_out = ptag_reg[2][7:0];
    assign fan2    = {1'b0, idx_out} + 9'd1;

    // the scaling outputs are already the output register
    assign rsp.valid       = pv_reg[2];
    assign rsp.bad_request = bad_out;
    assign rsp.rim_x       = bad_out ? '0 : rx;
    assign rsp.rim_y       = bad_out ? '0 : ry;
    assign rsp.fill_x      = bad_out ? '0 : fx;
    assign rsp.fill_y      = bad_out ? '0 : fy;
    assign rsp.fan_second  = bad_out ? '0 : fan2;
    assign rsp.fan_third   = bad_out ? '0 :
                             ((fan2 == side_count_reg) ? 9'd1 : fan2 + 9'd1);

`ifndef SYNTHESIS
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.rim_x))
        else $error("result changed under stall");
    a_fan: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.bad_request |-> rsp.fan_second != 9'd0)
        else $error("fan index zero on good result");
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.bad_request |-> rsp.rim_x == '0 && rsp.fan_third == '0)
        else $error("rejected result not cleared");
`endif
endmodule

// ===== tb/circle_polygon_vertex_generator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_polygon_vertex_generator_test: self-checking vertex generator bench
// Drives vertex requests and register writes through valid/ready channels.
// A built-in rotation model predicts every result item, which is then checked
// field by field. Sender and receiver idle at random in several phases.
// ----------------------------------------------------------------------------
module circle_polygon_vertex_generator_test;
    import cpvg_pkg::*;

    localparam int MAX_SIDES  = 256;
    localparam int LATENCY    = 50;
    localparam int CYCLE_STOP = 1500000;

    typedef struct packed {
        logic [COORD_W-1:0] rim_x;
        logic [COORD_W-1:0] rim_y;
        logic [COORD_W-1:0] fill_x;
        logic [COORD_W-1:0] fill_y;
        logic [8:0]         fan_second;
        logic [8:0]         fan_third;
        logic               bad_request;
    } vertex_t;

    logic clk;
    logic rst_n;

    cpvg_in_if  req ();
    cpvg_out_if rsp ();
    cpvg_cfg_if cfg ();

    circle_polygon_vertex_generator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    // Shadow copy of the block's registers
    logic [8:0]  sides_q;
    logic [15:0] radius_q;
    logic [15:0] outline_q;

    vertex_t pending_vertices[$];
    int      send_idle_pct;
    int      stall_pct;
    bit      hold_off;
    int      hold_cycles;
    int      errors;
    longint  cycle_count;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic [COORD_W-1:0] scale_point(longint r, longint radius,
                                                       longint unit);
        longint v;
        v = r + floor_shift(radius * unit + (64'sd1 <<< (UNIT_SHIFT - 1)), UNIT_SHIFT);
        if (v < 0)
            v = 0;
        if (v > (64'sd1 <<< COORD_W) - 1)
            v = (64'sd1 <<< COORD_W) - 1;
        return v[COORD_W-1:0];
    endfunction

    function automatic vertex_t predict_vertex(logic [7:0] idx);
        vertex_t  v;
        longint   ph;
        longint   x;
        longint   y;
        longint   z;
        longint   dx;
        longint   dy;
        longint   c;
        longint   s;
        longint   rad;
        longint   inner;
        longint   atan_k[CORDIC_STEPS];
        atan_k = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
                   10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5};
        v = '0;
        if (sides_q < 3 || sides_q > MAX_SIDES || idx >= sides_q || outline_q >= radius_q)
        begin
            v.bad_request = 1'b1;
            return v;
        end
        ph = (longint'(idx) << PHASE_BITS) / sides_q;
        z = ph & ((64'sd1 << (PHASE_BITS - 2)) - 1);
        x = CORDIC_START;
        y = 0;
        for (int k = 0; k < CORDIC_STEPS; k++)
        begin
            dx = floor_shift(y, k);
            dy = floor_shift(x, k);
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - atan_k[k];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + atan_k[k];
            end
        end
        case ((ph >> (PHASE_BITS - 2)) & 3)
            0:
            begin
                c = x;
                s = y;
            end
            1:
            begin
                c = -y;
                s = x;
            end
            2:
            begin
                c = -x;
                s = -y;
            end
            default:
            begin
                c = y;
                s = -x;
            end
        endcase
        rad = radius_q;
        inner = radius_q - outline_q;
        v.rim_x = scale_point(rad, rad, c);
        v.rim_y = scale_point(rad, rad, s);
        v.fill_x = scale_point(rad, inner, c);
        v.fill_y = scale_point(rad, inner, s);
        v.fan_second = idx + 9'd1;
        v.fan_third = (idx + 9'd1 == sides_q) ? 9'd1 : idx + 9'd2;
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Clock, cycle limit
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_STOP)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: drive ready at the falling edge, sample at the rising edge
    // ------------------------------------------------------------------
    initial
    begin
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp.ready <= !hold_off && ($urandom_range(99) >= stall_pct);
        end
    end

    // Count down a long hold-off so the pipeline fills and backs up
    initial
    begin
        hold_off = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                hold_off = 1'b1;
                hold_cycles--;
            end
            else
                hold_off = 1'b0;
        end
    end

    task automatic check_field(input string name, input logic [COORD_W-1:0] want_v,
                               input logic [COORD_W-1:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t %s exp %0d got %0d", $time, name, want_v, got_v);
            errors++;
        end
    endtask

    // Check each result item against the oldest prediction
    initial
    begin
        vertex_t got;
        vertex_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp.valid && rsp.ready)
            begin
                got = '{rsp.rim_x, rsp.rim_y, rsp.fill_x, rsp.fill_y,
                        rsp.fan_second, rsp.fan_third, rsp.bad_request};
                if (pending_vertices.size() == 0)
                begin
                    $display("%0t unexpected result item exp none got %h", $time, got);
                    errors++;
                end
                else
                begin
                    want = pending_vertices.pop_front();
                    check_field("rim_x", want.rim_x, got.rim_x);
                    check_field("rim_y", want.rim_y, got.rim_y);
                    check_field("fill_x", want.fill_x, got.fill_x);
                    check_field("fill_y", want.fill_y, got.fill_y);
                    check_field("fan_second", COORD_W'(want.fan_second),
                                COORD_W'(got.fan_second));
                    check_field("fan_third", COORD_W'(want.fan_third),
                                COORD_W'(got.fan_third));
                    check_field("bad_request", COORD_W'(want.bad_request),
                                COORD_W'(got.bad_request));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender tasks
    // ------------------------------------------------------------------
    // Ends at a falling edge with valid still high; the next send or a drain
    // decides what valid does from there.
    task automatic send_vertex(input logic [7:0] idx);
        bit idle;
        idle = ($urandom_range(99) < send_idle_pct);
        while (idle)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
            idle = ($urandom_range(99) < send_idle_pct);
        end
        req.valid <= 1'b1;
        req.vertex_index <= idx;
        do
            @(posedge clk);
        while (!req.ready);
        pending_vertices = {pending_vertices, predict_vertex(idx)};
        @(negedge clk);
    endtask

    // Drop valid, wait for every result, then let the pipeline drain
    task automatic drain;
        req.valid <= 1'b0;
        while (pending_vertices.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 5) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [15:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
        case (idx)
            REG_SIDE_COUNT:    sides_q = value[8:0];
            REG_CIRCLE_RADIUS: radius_q = value;
            REG_OUTLINE_WIDTH: outline_q = value;
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic set_circle(input logic [8:0] sides, input logic [15:0] r,
                              input logic [15:0] t);
        drain();
        write_reg(REG_SIDE_COUNT, {7'd0, sides});
        write_reg(REG_CIRCLE_RADIUS, r);
        write_reg(REG_OUTLINE_WIDTH, t);
        cfg.valid <= 1'b0;
    endtask

    // Mostly in-range indexes, some just past the end, some anywhere
    function automatic logic [7:0] pick_index();
        int roll;
        roll = $urandom_range(99);
        if (roll < 80 && sides_q != 0)
            return 8'($urandom_range((sides_q > 9'd256 ? 9'd256 : sides_q) - 9'd1));
        if (roll < 88)
            return sides_q[7:0];
        return 8'($urandom_range(255));
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_reset_defaults;
        send_vertex(8'd0);
        send_vertex(8'd8);
        send_vertex(8'd31);
        send_vertex(8'd32);
        send_vertex(8'd255);
    endtask

    task automatic test_directed_cases;
        // largest polygon, full index range, thick outline
        set_circle(9'd256, 16'hFFFF, 16'h7FFF);
        send_vertex(8'd0);
        send_vertex(8'd64);
        send_vertex(8'd128);
        send_vertex(8'd255);
        // triangle, last vertex wraps
        set_circle(9'd3, 16'd1600, 16'd0);
        send_vertex(8'd2);
        send_vertex(8'd3);
        // side count too small, then too large
        set_circle(9'd2, 16'd100, 16'd0);
        send_vertex(8'd0);
        set_circle(9'd257, 16'd100, 16'd0);
        send_vertex(8'd0);
        set_circle(9'd511, 16'd100, 16'd0);
        send_vertex(8'd1);
        // outline equal to radius, zero radius, unit radius, outline just under radius
        set_circle(9'd8, 16'd100, 16'd100);
        send_vertex(8'd1);
        set_circle(9'd8, 16'd0, 16'd0);
        send_vertex(8'd1);
        set_circle(9'd8, 16'd1, 16'd0);
        send_vertex(8'd3);
        send_vertex(8'd7);
        set_circle(9'd8, 16'hFFFF, 16'hFFFE);
        send_vertex(8'd5);
    endtask

    task automatic run_random(input int count, input int idle, input int stall);
        logic [15:0] r;
        send_idle_pct = idle;
        stall_pct = stall;
        for (int n = 0; n < count; n++)
        begin
            if (n % 60 == 0)
            begin
                r = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(2048));
                set_circle(($urandom_range(9) == 0) ? 9'($urandom) : 9'($urandom_range(256, 3)),
                           r,
                           ($urandom_range(4) == 0) ? 16'($urandom)
                               : ($urandom_range(1) ? 16'd0 : 16'($urandom_range(r))));
            end
            send_vertex(pick_index());
        end
    endtask

    // Hold the receiver off while the sender keeps offering items
    task automatic test_backpressure;
        send_idle_pct = 0;
        stall_pct = 0;
        set_circle(9'd200, 16'd3000, 16'd500);
        hold_cycles = 3 * LATENCY;
        for (int n = 0; n < 120; n++)
            send_vertex(8'($urandom_range(199)));
    endtask

    initial
    begin
        errors = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_cycles = 0;
        sides_q = 9'd32;
        radius_q = 16'd4096;
        outline_q = 16'd0;
        req.valid = 1'b0;
        req.vertex_index = '0;
        cfg.valid = 1'b0;
        cfg.index = REG_SIDE_COUNT;
        cfg.data = '0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_directed_cases();
        test_backpressure();
        run_random(450, 0, 0);
        run_random(450, 52, 0);
        run_random(450, 0, 52);
        run_random(450, 35, 35);

        drain();
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
design/cpvg_pkg.sv
design/cpvg_if.sv
design/cpvg_divider.sv
design/cpvg_cordic.sv
design/cpvg_place.sv
design/circle_polygon_vertex_generator.sv
tb/circle_polygon_vertex_generator_test.sv
